/* rtl/ntr_pkg.sv */
// ----------------------------------------------------------------------------
// Normal texel renormalize package
// Shared types and constants for the renormalize pipeline: the per-channel
// search lane, the texel record that travels down the pipeline and the
// fixed widths of the datapath.
// ----------------------------------------------------------------------------
package ntr_pkg;

   // Number of colour channels in a texel (red, green, blue).
   localparam int NumChannels  = 3;
   // Search steps after the sign of the code is known (bits 6 down to 0).
   localparam int SearchSteps  = 7;
   // Front stage, set-up stage, then one stage per search step.
   localparam int NumStages    = 2 + SearchSteps;

   // Datapath widths.
   localparam int DsqWidth     = 16;   // |d|^2, |d| <= 255
   localparam int SumWidth     = 18;   // S <= 3 * 65025
   localparam int RhsWidth     = 32;   // 65025 * |d|^2
   localparam int AsqWidth     = 15;   // a^2, a <= 128
   localparam int ProdWidth    = 35;   // 4 * a^2 * S

   // 255^2: the squared full-scale factor of the encoding.
   localparam logic [DsqWidth-1:0] ScaleSq  = 16'd65025;
   // Starting magnitude and its square for a negative component.
   localparam logic [7:0]          NegStart = 8'd128;
   localparam logic [AsqWidth-1:0] NegStartSq = 15'd16384;

   // One channel of the search: sign of d, current distance from code 128,
   // its square and the fixed right-hand side of the comparison.
   typedef struct packed {
      logic                neg;
      logic [7:0]          a;
      logic [AsqWidth-1:0] asq;
      logic [RhsWidth-1:0] rhs;
   } lane_type;

   // Texel record carried through the search stages.
   typedef struct packed {
      logic [7:0]                    alpha;
      logic [SumWidth-1:0]           s;
      lane_type [NumChannels-1:0]    lanes;
   } search_type;

endpackage

/* rtl/ntr_search_step.sv */
// ----------------------------------------------------------------------------
// Renormalize search step
// One pipeline stage of the per-channel binary search. It tries one more
// bit of the code in each channel, decides it by an exact squared comparison
// and registers the updated record.
// ----------------------------------------------------------------------------
module ntr_search_step import ntr_pkg::*; #(
   parameter int BitPos = 6
) (
   input  logic       clock,
   input  logic       enable,
   input  search_type stage_in,
   output search_type stage_out
);

   localparam logic [7:0]          StepA  = 8'(1 << BitPos);
   localparam logic [AsqWidth-1:0] StepSq = AsqWidth'(1 << (2 * BitPos));

   search_type stage_ff;
   search_type stage_in_c;

   logic [7:0]           cand_a     [NumChannels];
   logic [AsqWidth-1:0]  cross_term [NumChannels];
   logic [AsqWidth-1:0]  cand_sq    [NumChannels];
   logic [AsqWidth+1:0]  lhs_sc     [NumChannels];
   logic [ProdWidth-1:0] prod       [NumChannels];
   logic                 take       [NumChannels];

   // Candidate code per channel: move one step towards the far end of the
   // half chosen by the sign, update the square incrementally and keep the
   // step when 4*a^2*S stays on the right side of 65025*d^2.
   always_comb begin
      stage_in_c = stage_in;
      for (int i = 0; i < NumChannels; i++) begin
         cross_term[i] = AsqWidth'(stage_in.lanes[i].a) << (BitPos + 1);
         if (stage_in.lanes[i].neg) begin
            cand_a[i]  = stage_in.lanes[i].a - StepA;
            cand_sq[i] = stage_in.lanes[i].asq - cross_term[i] + StepSq;
         end else begin
            cand_a[i]  = stage_in.lanes[i].a + StepA;
            cand_sq[i] = stage_in.lanes[i].asq + cross_term[i] + StepSq;
         end
         lhs_sc[i] = {cand_sq[i], 2'b00};
         prod[i]   = ProdWidth'(lhs_sc[i]) * ProdWidth'(stage_in.s);
         if (stage_in.lanes[i].neg) begin
            take[i] = prod[i] >= ProdWidth'(stage_in.lanes[i].rhs);
         end else begin
            take[i] = prod[i] <= ProdWidth'(stage_in.lanes[i].rhs);
         end
         if (take[i]) begin
            stage_in_c.lanes[i].a   = cand_a[i];
            stage_in_c.lanes[i].asq = cand_sq[i];
         end
      end
   end

   // Stage register; validity is tracked by the top level.
   always_ff @(posedge clock) begin
      if (enable) begin
         stage_ff <= stage_in_c;
      end
   end

   assign stage_out = stage_ff;

endmodule

/* rtl/normal_texel_renormalize_unit.sv */
// ----------------------------------------------------------------------------
// Normal texel renormalize unit
// Rescales the RGB vector of an ARGB8888 normal-map texel to unit length and
// re-encodes each channel, copying alpha through.
// ----------------------------------------------------------------------------
// The unit accepts one texel per clock while req_stall is low and returns the
// results in order. A front stage forms the channel magnitudes and their
// squares, a set-up stage forms the squared length and the comparison
// targets, and seven search stages settle the code bits, each with one
// 17 x 18 bit multiplier per channel, nine register stages in all. Each code
// is the exact floor of 128 + 127.5 * d / sqrt(S). Every stage advances
// whenever the stage after it is empty or moving, so empty slots close up
// while the result side stalls and no transaction is lost or repeated.
module normal_texel_renormalize_unit import ntr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_texel_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_texel_out
);

   logic [NumStages-1:0] valid_ff;
   logic [NumStages-1:0] valid_in;
   logic [NumStages-1:0] enable;

   // Front stage payload.
   logic [7:0]          alpha_ff;
   logic [NumChannels-1:0] neg_ff;
   logic [DsqWidth-1:0] dsq_ff [NumChannels];
   logic [NumChannels-1:0] neg_in;
   logic [DsqWidth-1:0] dsq_in [NumChannels];
   logic [7:0]          abs_d  [NumChannels];
   logic [7:0]          chan   [NumChannels];

   // Search records: entry 0 is the set-up stage, entry k+1 follows step k.
   search_type srch [SearchSteps+1];
   search_type setup_in;
   search_type setup_ff;

   logic [7:0] code [NumChannels];

   // Stage enables: a stage may load when it is empty or its successor moves.
   always_comb begin
      enable[NumStages-1] = !valid_ff[NumStages-1] || !rsp_stall;
      for (int i = NumStages - 2; i >= 0; i--) begin
         enable[i] = !valid_ff[i] || enable[i+1];
      end
      valid_in[0] = req_valid;
      for (int i = 1; i < NumStages; i++) begin
         valid_in[i] = valid_ff[i-1];
      end
   end

   assign req_stall = !enable[0];

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NumStages; i++) begin
            if (enable[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   // Front stage: d = 2c - 255 is odd, so |d| is the low seven bits of c
   // (inverted when c is below 128) with a one appended.
   always_comb begin
      chan[2] = req_texel_in[23:16];
      chan[1] = req_texel_in[15:8];
      chan[0] = req_texel_in[7:0];
      for (int i = 0; i < NumChannels; i++) begin
         neg_in[i] = !chan[i][7];
         abs_d[i]  = chan[i][7] ? {chan[i][6:0], 1'b1} : {~chan[i][6:0], 1'b1};
         dsq_in[i] = DsqWidth'(abs_d[i]) * DsqWidth'(abs_d[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (enable[0]) begin
         alpha_ff <= req_texel_in[31:24];
         neg_ff   <= neg_in;
         for (int i = 0; i < NumChannels; i++) begin
            dsq_ff[i] <= dsq_in[i];
         end
      end
   end

   // Set-up stage: squared length, comparison targets and search start.
   // The sign alone fixes the top code bit.
   always_comb begin
      setup_in.alpha = alpha_ff;
      setup_in.s     = SumWidth'(dsq_ff[0]) + SumWidth'(dsq_ff[1])
                     + SumWidth'(dsq_ff[2]);
      for (int i = 0; i < NumChannels; i++) begin
         setup_in.lanes[i].neg = neg_ff[i];
         setup_in.lanes[i].a   = neg_ff[i] ? NegStart : 8'd0;
         setup_in.lanes[i].asq = neg_ff[i] ? NegStartSq : '0;
         setup_in.lanes[i].rhs = RhsWidth'(ScaleSq) * RhsWidth'(dsq_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (enable[1]) begin
         setup_ff <= setup_in;
      end
   end

   assign srch[0] = setup_ff;

   // Search stages, most significant remaining bit first.
   for (genvar k = 0; k < SearchSteps; k++) begin : g_step
      ntr_search_step #(
         .BitPos (SearchSteps - 1 - k)
      ) u_step (
         .clock     (clock),
         .enable    (enable[k+2]),
         .stage_in  (srch[k]),
         .stage_out (srch[k+1])
      );
   end

   // Output encoding: positive components sit at 128 + a, negative ones at
   // 128 - a.
   always_comb begin
      for (int i = 0; i < NumChannels; i++) begin
         if (srch[SearchSteps].lanes[i].neg) begin
            code[i] = NegStart - srch[SearchSteps].lanes[i].a;
         end else begin
            code[i] = {1'b1, srch[SearchSteps].lanes[i].a[6:0]};
         end
      end
   end

   assign rsp_valid     = valid_ff[NumStages-1];
   assign rsp_texel_out = {srch[SearchSteps].alpha, code[2], code[1], code[0]};

endmodule
